FILE: hdl/fapd_pkg.sv
// Package for the four-corner charge-division position core.
// Widths, pipeline depth and register map. No dependencies.
`timescale 1ns / 1ps

package fapd_pkg;

  localparam int unsigned NumCorners  = 4;
  localparam int unsigned AmpW        = 16;              // corner amplitude
  localparam int unsigned PairW       = AmpW + 1;        // sum of two corners
  localparam int unsigned SumW        = AmpW + 2;        // sum of four corners
  localparam int unsigned PosW        = 18;              // Q2.16 position
  localparam int unsigned RemW        = SumW + 1;        // partial remainder
  localparam int unsigned NumDivSteps = PosW;            // one quotient bit per stage
  localparam int unsigned NumStages   = NumDivSteps + 1; // window stage + divider

  localparam logic [PosW-1:0] QTwo = PosW'(131072);      // 2.0 in Q2.16

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  typedef enum logic [RegIdxW-1:0] {
    RegUrMin = 3'd0,
    RegLrMin = 3'd1,
    RegUlMin = 3'd2,
    RegLlMin = 3'd3,
    RegUrMax = 3'd4,
    RegLrMax = 3'd5,
    RegUlMax = 3'd6,
    RegLlMax = 3'd7
  } reg_idx_e;

endpackage

FILE: hdl/four_anode_position_divider_core.sv
// Four-corner charge-division position core: window check, sum, two
// pipelined restoring dividers for X and Y. Depends on fapd_pkg.
// The window/sum stage loads the input word when it is taken; it is followed by
// 18 divider stages and one output register. Throughput: one word per cycle
// while the output is not stalled; the restoring dividers retire one quotient
// bit per stage.
// Reset (rst_ni low, async): pipeline emptied, windows set to [0, 65535].
`timescale 1ns / 1ps

module four_anode_position_divider_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fapd_pkg::AmpW-1:0]     upper_right_i,
  input  logic [fapd_pkg::AmpW-1:0]     lower_right_i,
  input  logic [fapd_pkg::AmpW-1:0]     upper_left_i,
  input  logic [fapd_pkg::AmpW-1:0]     lower_left_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic [fapd_pkg::SumW-1:0]     amplitude_sum_o,
  output logic [fapd_pkg::PosW-1:0]     x_position_o,
  output logic [fapd_pkg::PosW-1:0]     y_position_o,
  // APB-style register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fapd_pkg::CfgAddrW-1:0] paddr,
  input  logic [fapd_pkg::CfgDataW-1:0] pwdata,
  output logic [fapd_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------------
  // Window registers, one min and one max per corner.
  // Corner order: upper right, lower right, upper left, lower left.
  // ---------------------------------------------------------------------------
  logic [fapd_pkg::NumCorners-1:0][fapd_pkg::AmpW-1:0] win_min_q, win_min_d;
  logic [fapd_pkg::NumCorners-1:0][fapd_pkg::AmpW-1:0] win_max_q, win_max_d;
  logic                                                cfg_wr;
  fapd_pkg::reg_idx_e                                  cfg_idx;
  logic [fapd_pkg::AmpW-1:0]                           cfg_val;
  logic [fapd_pkg::AmpW-1:0]                           rd_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = fapd_pkg::reg_idx_e'(paddr[fapd_pkg::CfgAddrW-1:2]);
  assign cfg_val = pwdata[fapd_pkg::AmpW-1:0];

  always_comb begin
    win_min_d = win_min_q;
    win_max_d = win_max_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        fapd_pkg::RegUrMin: win_min_d[0] = cfg_val;
        fapd_pkg::RegLrMin: win_min_d[1] = cfg_val;
        fapd_pkg::RegUlMin: win_min_d[2] = cfg_val;
        fapd_pkg::RegLlMin: win_min_d[3] = cfg_val;
        fapd_pkg::RegUrMax: win_max_d[0] = cfg_val;
        fapd_pkg::RegLrMax: win_max_d[1] = cfg_val;
        fapd_pkg::RegUlMax: win_max_d[2] = cfg_val;
        fapd_pkg::RegLlMax: win_max_d[3] = cfg_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fapd_pkg::RegUrMin: rd_val = win_min_q[0];
      fapd_pkg::RegLrMin: rd_val = win_min_q[1];
      fapd_pkg::RegUlMin: rd_val = win_min_q[2];
      fapd_pkg::RegLlMin: rd_val = win_min_q[3];
      fapd_pkg::RegUrMax: rd_val = win_max_q[0];
      fapd_pkg::RegLrMax: rd_val = win_max_q[1];
      fapd_pkg::RegUlMax: rd_val = win_max_q[2];
      fapd_pkg::RegLlMax: rd_val = win_max_q[3];
      default:            rd_val = '0;
    endcase
  end

  assign prdata = fapd_pkg::CfgDataW'(rd_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_min_q <= '0;
      win_max_q <= '1;
    end else begin
      win_min_q <= win_min_d;
      win_max_q <= win_max_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline. Stage 0 holds the window verdict, the sum and the two pair
  // sums (the dividends). Stages 1..18 each produce one quotient bit of
  // X and Y, MSB first. Every stage moves on when its successor is empty
  // or moving, so bubbles close up while the output is stalled.
  // ---------------------------------------------------------------------------
  localparam int unsigned NS = fapd_pkg::NumStages;

  logic [NS-1:0]                        v_q;
  logic [NS-1:0]                        en;
  logic [NS-1:0]                        ok_q,  ok_d;
  logic [NS-1:0][fapd_pkg::SumW-1:0]    sum_q, sum_d;
  logic [NS-1:0][fapd_pkg::RemW-1:0]    rx_q,  rx_d;
  logic [NS-1:0][fapd_pkg::RemW-1:0]    ry_q,  ry_d;
  logic [NS-1:0][fapd_pkg::PosW-1:0]    qx_q,  qx_d;
  logic [NS-1:0][fapd_pkg::PosW-1:0]    qy_q,  qy_d;

  logic                                 out_v_q;
  logic                                 out_en;
  logic                                 acc_q;
  logic [fapd_pkg::SumW-1:0]            osum_q;
  logic [fapd_pkg::PosW-1:0]            ox_q, oy_q;

  // stall chain, back to front
  assign out_en = ~out_v_q | out_ready_i;
  always_comb begin
    en[NS-1] = ~v_q[NS-1] | out_en;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end
  assign in_ready_o = en[0];

  // stage 0: window check and sums
  logic [fapd_pkg::NumCorners-1:0][fapd_pkg::AmpW-1:0] amp;
  logic [fapd_pkg::NumCorners-1:0]                     in_win;
  logic [fapd_pkg::SumW-1:0]                           sum_in;
  logic [fapd_pkg::PairW-1:0]                          right_in, upper_in;

  assign amp = {lower_left_i, upper_left_i, lower_right_i, upper_right_i};

  always_comb begin
    for (int c = 0; c < fapd_pkg::NumCorners; c++) begin
      in_win[c] = (amp[c] >= win_min_q[c]) && (amp[c] <= win_max_q[c]);
    end
  end

  assign right_in = fapd_pkg::PairW'(upper_right_i) + fapd_pkg::PairW'(lower_right_i);
  assign upper_in = fapd_pkg::PairW'(upper_right_i) + fapd_pkg::PairW'(upper_left_i);
  assign sum_in   = fapd_pkg::SumW'(right_in)
                  + fapd_pkg::SumW'(upper_left_i) + fapd_pkg::SumW'(lower_left_i);

  // divider steps: the first step compares the dividend as is (it never
  // exceeds the sum, so the quotient fits Q2.16), later ones shift in a zero
  logic [NS-1:0][fapd_pkg::RemW-1:0] tx, ty;
  logic [NS-1:0]                     gex, gey;

  always_comb begin
    ok_d[0]  = (&in_win) && (sum_in != '0);
    sum_d[0] = sum_in;
    rx_d[0]  = fapd_pkg::RemW'(right_in);
    ry_d[0]  = fapd_pkg::RemW'(upper_in);
    qx_d[0]  = '0;
    qy_d[0]  = '0;
    tx[0]    = '0;
    ty[0]    = '0;
    gex[0]   = 1'b0;
    gey[0]   = 1'b0;
    for (int s = 1; s < NS; s++) begin
      if (s == 1) begin
        tx[s] = rx_q[s-1];
        ty[s] = ry_q[s-1];
      end else begin
        tx[s] = {rx_q[s-1][fapd_pkg::RemW-2:0], 1'b0};
        ty[s] = {ry_q[s-1][fapd_pkg::RemW-2:0], 1'b0};
      end
      gex[s]   = tx[s] >= fapd_pkg::RemW'(sum_q[s-1]);
      gey[s]   = ty[s] >= fapd_pkg::RemW'(sum_q[s-1]);
      rx_d[s]  = gex[s] ? tx[s] - fapd_pkg::RemW'(sum_q[s-1]) : tx[s];
      ry_d[s]  = gey[s] ? ty[s] - fapd_pkg::RemW'(sum_q[s-1]) : ty[s];
      qx_d[s]  = {qx_q[s-1][fapd_pkg::PosW-2:0], gex[s]};
      qy_d[s]  = {qy_q[s-1][fapd_pkg::PosW-2:0], gey[s]};
      ok_d[s]  = ok_q[s-1];
      sum_d[s] = sum_q[s-1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
      if (out_en) out_v_q <= v_q[NS-1];
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        ok_q[k]  <= ok_d[k];
        sum_q[k] <= sum_d[k];
        rx_q[k]  <= rx_d[k];
        ry_q[k]  <= ry_d[k];
        qx_q[k]  <= qx_d[k];
        qy_q[k]  <= qy_d[k];
      end
    end
    if (out_en) begin
      // rejected words report sum 0 and position 2.0
      acc_q  <= ok_q[NS-1];
      osum_q <= ok_q[NS-1] ? sum_q[NS-1] : '0;
      ox_q   <= ok_q[NS-1] ? qx_q[NS-1]  : fapd_pkg::QTwo;
      oy_q   <= ok_q[NS-1] ? qy_q[NS-1]  : fapd_pkg::QTwo;
    end
  end

  assign out_valid_o     = out_v_q;
  assign accepted_o      = acc_q;
  assign amplitude_sum_o = osum_q;
  assign x_position_o    = ox_q;
  assign y_position_o    = oy_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |->
      (x_position_o <= fapd_pkg::QTwo) && (y_position_o <= fapd_pkg::QTwo))
    else $error("position beyond 2.0 on an accepted word");

  a_sum_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> amplitude_sum_o != '0)
    else $error("accepted word with zero sum");

  a_bubble_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> in_ready_o)
    else $error("input stalled although first stage is empty");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !out_v_q |=> out_v_q)
    else $error("last divider stage did not move into empty output register");

endmodule

FILE: dv/four_anode_position_divider_core_test.sv
// Self-checking testbench for four_anode_position_divider_core: windowed
// four-corner sums and Q2.16 X/Y positions, checked word by word against a predictor or typed-in words.
// Depends on fapd_pkg and the core RTL only.
`timescale 1ns / 1ps

module four_anode_position_divider_core_test;

  // Run shape
  localparam int NumPhases     = 8;
  localparam int WordsPerPhase = 125;
  localparam int HoldOffCycles = 120;               // long receiver stall
  localparam int TailCycles    = 2 * fapd_pkg::NumStages + 4; // settle after the last word
  // No transfer on any port for this long means a hang. The slowest
  // correct stretch is a hold-off plus a pipeline drain plus random gaps.
  localparam int StallLimit    = 2000;
  localparam int NumProbes     = 21;

  // One event: the four corner amplitudes
  typedef struct packed {
    logic [fapd_pkg::AmpW-1:0] ur;
    logic [fapd_pkg::AmpW-1:0] lr;
    logic [fapd_pkg::AmpW-1:0] ul;
    logic [fapd_pkg::AmpW-1:0] ll;
  } corner_word_t;

  // One result word
  typedef struct packed {
    logic                      accepted;
    logic [fapd_pkg::SumW-1:0] amp_sum;
    logic [fapd_pkg::PosW-1:0] x_pos;
    logic [fapd_pkg::PosW-1:0] y_pos;
  } position_word_t;

  // Directed row: narrow selects the [100, 200] windows, known means the
  // expected word is typed in rather than predicted.
  typedef struct packed {
    bit             narrow;
    bit             known;
    corner_word_t   ev;
    position_word_t want;
  } corner_probe_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [fapd_pkg::AmpW-1:0]     upper_right_i;
  logic [fapd_pkg::AmpW-1:0]     lower_right_i;
  logic [fapd_pkg::AmpW-1:0]     upper_left_i;
  logic [fapd_pkg::AmpW-1:0]     lower_left_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          accepted_o;
  logic [fapd_pkg::SumW-1:0]     amplitude_sum_o;
  logic [fapd_pkg::PosW-1:0]     x_position_o;
  logic [fapd_pkg::PosW-1:0]     y_position_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [fapd_pkg::CfgAddrW-1:0] paddr;
  logic [fapd_pkg::CfgDataW-1:0] pwdata;
  logic [fapd_pkg::CfgDataW-1:0] prdata;
  logic                          pready;

  // Predictor's copy of the corner windows
  logic [fapd_pkg::AmpW-1:0] win_lo [fapd_pkg::NumCorners];
  logic [fapd_pkg::AmpW-1:0] win_hi [fapd_pkg::NumCorners];

  position_word_t pending_results [$];   // expected words, oldest first
  position_word_t head;
  int             mismatches = 0;
  int             words_sent = 0;
  bit             steady_in  = 1'b0;     // sender stretch with no gaps

  // Directed table. Known rows: extremes under the reset windows, plus the
  // edges of a [100, 200] window on every corner.
  corner_probe_t probe_table [NumProbes] = '{
    // all corners zero: sum is zero, rejected
    '{1'b0, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000},
      '{1'b0, 18'd0, fapd_pkg::QTwo, fapd_pkg::QTwo}},
    // all corners full scale: centered
    '{1'b0, 1'b1, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{1'b1, 18'd262140, 18'd65536, 18'd65536}},
    // one corner at a time: positions hit the 0 and 2.0 rails
    '{1'b0, 1'b1, '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000},
      '{1'b1, 18'd65535, 18'd131072, 18'd131072}},
    '{1'b0, 1'b1, '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000},
      '{1'b1, 18'd65535, 18'd131072, 18'd0}},
    '{1'b0, 1'b1, '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000},
      '{1'b1, 18'd65535, 18'd0, 18'd131072}},
    '{1'b0, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF},
      '{1'b1, 18'd65535, 18'd0, 18'd0}},
    // smallest nonzero sum
    '{1'b0, 1'b1, '{16'h0001, 16'h0000, 16'h0000, 16'h0000},
      '{1'b1, 18'd1, 18'd131072, 18'd131072}},
    '{1'b0, 1'b1, '{16'h0001, 16'h0001, 16'h0001, 16'h0001},
      '{1'b1, 18'd4, 18'd65536, 18'd65536}},
    // inexact quotients, floored
    '{1'b0, 1'b0, '{16'h0001, 16'h0000, 16'h0000, 16'h0002}, '0},
    '{1'b0, 1'b0, '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, '0},
    '{1'b0, 1'b0, '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, '0},
    '{1'b0, 1'b0, '{16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE}, '0},
    '{1'b0, 1'b0, '{16'hFFFF, 16'h0000, 16'h0000, 16'h0001}, '0},
    '{1'b0, 1'b0, '{16'h0003, 16'h0005, 16'h0007, 16'h000B}, '0},
    '{1'b0, 1'b0, '{16'h1234, 16'hABCD, 16'hFEDC, 16'h0F0F}, '0},
    // window edges: min and max are inclusive
    '{1'b1, 1'b1, '{16'd100, 16'd100, 16'd100, 16'd100},
      '{1'b1, 18'd400, 18'd65536, 18'd65536}},
    '{1'b1, 1'b1, '{16'd200, 16'd200, 16'd200, 16'd200},
      '{1'b1, 18'd800, 18'd65536, 18'd65536}},
    // one below min, one above max: rejected; mixed edges: accepted; a zero corner: rejected
    '{1'b1, 1'b1, '{16'd99, 16'd150, 16'd150, 16'd150},
      '{1'b0, 18'd0, fapd_pkg::QTwo, fapd_pkg::QTwo}},
    '{1'b1, 1'b1, '{16'd150, 16'd150, 16'd150, 16'd201},
      '{1'b0, 18'd0, fapd_pkg::QTwo, fapd_pkg::QTwo}},
    '{1'b1, 1'b0, '{16'd200, 16'd100, 16'd100, 16'd200}, '0},
    '{1'b1, 1'b1, '{16'd150, 16'd0, 16'd150, 16'd150},
      '{1'b0, 18'd0, fapd_pkg::QTwo, fapd_pkg::QTwo}}
  };

  four_anode_position_divider_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .upper_right_i  (upper_right_i),
    .lower_right_i  (lower_right_i),
    .upper_left_i   (upper_left_i),
    .lower_left_i   (lower_left_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accepted_o     (accepted_o),
    .amplitude_sum_o(amplitude_sum_o),
    .x_position_o   (x_position_o),
    .y_position_o   (y_position_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected word for one event under the current windows.
  // Positions: floor(2.0 * pair / sum) in Q2.16, rails at 2.0 when rejected.
  function automatic position_word_t predict_position(input corner_word_t w);
    logic [fapd_pkg::AmpW-1:0] amp [fapd_pkg::NumCorners];
    logic [fapd_pkg::SumW-1:0] total;
    bit                        in_window;
    longint unsigned           right_pair;
    longint unsigned           upper_pair;
    position_word_t            r;
    amp[0] = w.ur;
    amp[1] = w.lr;
    amp[2] = w.ul;
    amp[3] = w.ll;
    total = '0;
    in_window = 1'b1;
    for (int c = 0; c < fapd_pkg::NumCorners; c++) begin
      if (amp[c] < win_lo[c] || amp[c] > win_hi[c]) in_window = 1'b0;
      total += fapd_pkg::SumW'(amp[c]);
    end
    if (in_window && total != '0) begin
      right_pair = w.ur;
      right_pair += w.lr;
      upper_pair = w.ur;
      upper_pair += w.ul;
      r.accepted = 1'b1;
      r.amp_sum  = total;
      r.x_pos    = fapd_pkg::PosW'(right_pair * fapd_pkg::QTwo / total);
      r.y_pos    = fapd_pkg::PosW'(upper_pair * fapd_pkg::QTwo / total);
    end else begin
      r = '{1'b0, '0, fapd_pkg::QTwo, fapd_pkg::QTwo};
    end
    return r;
  endfunction

  // Corner amplitude: clean draws stay inside the window (edges weighted),
  // noise draws hit the rails, the values just outside, or anything.
  function automatic logic [fapd_pkg::AmpW-1:0] pick_amp(input int c, input bit clean);
    logic [fapd_pkg::AmpW-1:0] lo;
    logic [fapd_pkg::AmpW-1:0] hi;
    logic [fapd_pkg::AmpW-1:0] amp;
    lo = win_lo[c];
    hi = win_hi[c];
    if (clean && lo <= hi) begin
      case ($urandom_range(0, 7))
        0:       amp = lo;
        1:       amp = hi;
        default: amp = fapd_pkg::AmpW'($urandom_range(lo, hi));
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0:       amp = '0;
        1:       amp = '1;
        2:       amp = lo - 1'b1;
        3:       amp = hi + 1'b1;
        default: amp = fapd_pkg::AmpW'($urandom);
      endcase
    end
    return amp;
  endfunction

  // APB write: setup phase, access phase, then idle. Junk goes into the
  // upper half of pwdata; only the low 16 bits belong to the register.
  task automatic write_window(input fapd_pkg::reg_idx_e idx,
                              input logic [fapd_pkg::AmpW-1:0] value);
    int slot;
    slot = int'(idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fapd_pkg::CfgAddrW'(4 * slot);
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (slot < int'(fapd_pkg::RegUrMax)) win_lo[slot] = value;
    else win_hi[slot - int'(fapd_pkg::RegUrMax)] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Window settings per phase: wide open, full-scale only, zero only
  // (sum always zero), one corner inverted, single-value, then random.
  task automatic program_phase(input int phase);
    logic [fapd_pkg::AmpW-1:0] lo;
    logic [fapd_pkg::AmpW-1:0] hi;
    int                        odd_corner;
    odd_corner = $urandom_range(0, fapd_pkg::NumCorners - 1);
    for (int c = 0; c < fapd_pkg::NumCorners; c++) begin
      lo = fapd_pkg::AmpW'($urandom_range(0, 50000));
      hi = fapd_pkg::AmpW'($urandom_range(lo, 65535));
      case (phase)
        0: begin
          lo = '0;
          hi = '1;
        end
        1: begin
          lo = '1;
          hi = '1;
        end
        2: begin
          lo = '0;
          hi = '0;
        end
        3: if (c == odd_corner) begin
          lo = fapd_pkg::AmpW'($urandom_range(1, 65535));
          hi = fapd_pkg::AmpW'($urandom_range(0, lo - 1));
        end
        4: hi = lo;
        default: ;
      endcase
      write_window(fapd_pkg::reg_idx_e'(c), lo);
      write_window(fapd_pkg::reg_idx_e'(c + fapd_pkg::NumCorners), hi);
    end
  endtask

  // Offer one word and hold it until taken. Valid is only lowered when a
  // gap is drawn, so back-to-back words keep it high.
  task automatic send_word(input corner_word_t w, input position_word_t want);
    int gap;
    if (words_sent % 32 == 0) steady_in = ($urandom_range(0, 3) == 0);
    gap = steady_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    upper_right_i <= w.ur;
    lower_right_i <= w.lr;
    upper_left_i  <= w.ul;
    lower_left_i  <= w.ll;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(want);
    words_sent++;
  endtask

  // Sender stops and waits for every outstanding position word.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    corner_word_t   w;
    position_word_t expected;
    bit             narrow_set;
    bit             clean;
    narrow_set    = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    upper_right_i = '0;
    lower_right_i = '0;
    upper_left_i  = '0;
    lower_left_i  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    for (int c = 0; c < fapd_pkg::NumCorners; c++) begin
      win_lo[c] = '0;
      win_hi[c] = '1;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, reset windows first, then the narrow ones
    for (int i = 0; i < NumProbes; i++) begin
      if (probe_table[i].narrow && !narrow_set) begin
        drain_results();
        for (int c = 0; c < fapd_pkg::NumCorners; c++) begin
          write_window(fapd_pkg::reg_idx_e'(c), 16'd100);
          write_window(fapd_pkg::reg_idx_e'(c + fapd_pkg::NumCorners), 16'd200);
        end
        narrow_set = 1'b1;
      end
      expected = probe_table[i].known ? probe_table[i].want
                                      : predict_position(probe_table[i].ev);
      send_word(probe_table[i].ev, expected);
    end

    // Random phases. The drain at each boundary is also the sender pause
    // that lets the pipeline run completely dry.
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      program_phase(p);
      for (int n = 0; n < WordsPerPhase; n++) begin
        // mostly well-formed events, the rest noise
        clean = ($urandom_range(0, 9) < 7);
        w.ur  = pick_amp(0, clean);
        w.lr  = pick_amp(1, clean);
        w.ul  = pick_amp(2, clean);
        w.ll  = pick_amp(3, clean);
        send_word(w, predict_position(w));
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random backpressure per word, gap-free stretches, and two
  // long hold-offs that back the pipeline up into in_ready_o.
  initial begin
    int  taken;
    int  stall;
    bit  steady_out;
    taken      = 0;
    steady_out = 1'b0;
    out_ready_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken % 32 == 0) steady_out = ($urandom_range(0, 3) == 0);
      if (taken == 300 || taken == 800) stall = HoldOffCycles;
      else stall = steady_out ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Checker: every word taken on the output must match the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("position word with no event pending");
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (accepted_o !== head.accepted) begin
          $error("accepted: expected %0d, got %0d", head.accepted, accepted_o);
          mismatches++;
        end
        if (amplitude_sum_o !== head.amp_sum) begin
          $error("amplitude_sum: expected %0d, got %0d", head.amp_sum, amplitude_sum_o);
          mismatches++;
        end
        if (x_position_o !== head.x_pos) begin
          $error("x_position: expected %0d, got %0d", head.x_pos, x_position_o);
          mismatches++;
        end
        if (y_position_o !== head.y_pos) begin
          $error("y_position: expected %0d, got %0d", head.y_pos, y_position_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any word on either channel or any register access resets it
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (!rst_ni) @(posedge clk_i);
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

endmodule
